// ===== rtl/utf8_sanitizer_top_macros.svh =====
// Assertion macros shared by the UTF-8 sanitizer modules.
`ifndef UTF8_SANITIZER_TOP_MACROS_SVH
`define UTF8_SANITIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define U8S_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define U8S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/u8s_pkg.sv =====
// Shared types, constants and byte classifier for the UTF-8 sanitizer.
package u8s_pkg;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam int         GRP_MAX    = 4;
  localparam int         FIFO_DEPTH = 4;
  localparam int         FIFO_AW    = $clog2(FIFO_DEPTH);

  // Total length of the open sequence, none when zero
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } u8s_cls_t;

  // One group of result words caused by a single input word
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic [1:0]              cnt_m1;
    logic                    stream_end;
  } u8s_grp_t;

  function automatic u8s_cls_t u8s_classify(input logic [7:0] b);
    u8s_cls_t c;
    if (b[7] == 1'b0) begin
      c = CLS_ASCII;
    end else if (b[7:6] == 2'b10) begin
      c = CLS_CONT;
    end else if (b[7:5] == 3'b110) begin
      c = CLS_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      c = CLS_LEAD3;
    end else if (b[7:3] == 5'b11110) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_BAD;
    end
    return c;
  endfunction

endpackage

// ===== rtl/u8s_front.sv =====
// Front end: accepts bytes, tracks the open sequence and builds result groups.
`include "utf8_sanitizer_top_macros.svh"

module u8s_front
  import u8s_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [7:0] in_byte,
  input  logic     in_last,
  output logic     push_valid,
  input  logic     push_ready,
  output u8s_grp_t push_data
);

  logic [7:0]      lead_r, lead_nxt;
  logic [1:0][7:0] cont_r, cont_nxt;
  logic [2:0]      exp_len_r, exp_len_nxt;
  logic [1:0]      hcnt_r, hcnt_nxt;

  u8s_cls_t                cls;
  logic                    opened;
  logic [1:0]              flush_n;
  logic [2:0]              n_c;
  logic [GRP_MAX-1:0][7:0] bytes_c;
  logic                    accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Classify the word and work out the group and next sequence state
  always_comb begin
    cls         = u8s_classify(in_byte);
    opened      = (exp_len_r != LEN_NONE);
    flush_n     = opened ? (hcnt_r + 2'd1) : 2'd0;
    bytes_c     = {GRP_MAX{QMARK}};
    n_c         = 3'd0;
    lead_nxt    = lead_r;
    cont_nxt    = cont_r;
    exp_len_nxt = exp_len_r;
    hcnt_nxt    = hcnt_r;
    if (opened && (cls == CLS_CONT)) begin
      if (({1'b0, hcnt_r} + 3'd2) >= exp_len_r) begin
        // sequence complete: release it whole
        bytes_c           = {GRP_MAX{in_byte}};
        bytes_c[0]        = lead_r;
        if (hcnt_r != 2'd0) begin
          bytes_c[1] = cont_r[0];
        end
        if (hcnt_r == 2'd2) begin
          bytes_c[2] = cont_r[1];
        end
        n_c         = {1'b0, hcnt_r} + 3'd2;
        exp_len_nxt = LEN_NONE;
        hcnt_nxt    = 2'd0;
      end else begin
        // hold the continuation word
        cont_nxt[hcnt_r[0]] = in_byte;
        hcnt_nxt            = hcnt_r + 2'd1;
        if (in_last) begin
          n_c = {1'b0, hcnt_r} + 3'd2;
        end
      end
    end else begin
      // drop any open sequence as question marks, then handle the word as ASCII, a lead or a bad word
      exp_len_nxt = LEN_NONE;
      hcnt_nxt    = 2'd0;
      unique case (cls)
        CLS_ASCII: begin
          bytes_c[flush_n] = in_byte;
          n_c              = {1'b0, flush_n} + 3'd1;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          lead_nxt = in_byte;
          if (cls == CLS_LEAD2) begin
            exp_len_nxt = LEN_2;
          end else if (cls == CLS_LEAD3) begin
            exp_len_nxt = LEN_3;
          end else begin
            exp_len_nxt = LEN_4;
          end
          n_c = {1'b0, flush_n} + (in_last ? 3'd1 : 3'd0);
        end
        default: begin
          n_c = {1'b0, flush_n} + 3'd1;
        end
      endcase
    end
    // end of stream closes whatever is still open
    if (in_last) begin
      exp_len_nxt = LEN_NONE;
      hcnt_nxt    = 2'd0;
    end
  end

  assign push_valid           = in_valid && (n_c != 3'd0);
  assign push_data.bytes      = bytes_c;
  assign push_data.cnt_m1     = 2'(n_c - 3'd1);
  assign push_data.stream_end = in_last;

  // Advance sequence control state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= LEN_NONE;
      hcnt_r    <= 2'd0;
    end else if (accept) begin
      exp_len_r <= exp_len_nxt;
      hcnt_r    <= hcnt_nxt;
    end
  end

  // Hold lead and continuation words
  always_ff @(posedge clk) begin
    if (accept) begin
      lead_r <= lead_nxt;
      cont_r <= cont_nxt;
    end
  end

  `U8S_ASSERT_NOW(a_len_legal, 1'b1,
    (exp_len_r == LEN_NONE) || (exp_len_r == LEN_2) || (exp_len_r == LEN_3) ||
    (exp_len_r == LEN_4), "open length out of range")
  `U8S_ASSERT_NOW(a_hcnt_bound, exp_len_r != LEN_NONE,
    ({1'b0, hcnt_r} + 3'd2) <= exp_len_r, "held count reached the full length")

endmodule

// ===== rtl/u8s_fifo.sv =====
// Short group queue between the front end and the serialiser.
`include "utf8_sanitizer_top_macros.svh"

module u8s_fifo
  import u8s_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  u8s_grp_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output u8s_grp_t pop_data
);

  u8s_grp_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               push, pop;

  assign push_ready = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (FIFO_AW+1)'(1);
      end
    end
  end

  // Store the incoming group
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  `U8S_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH),
    "queue occupancy above depth")
  `U8S_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + (FIFO_AW+1)'(1),
    "occupancy did not rise on push")
  `U8S_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_r == $past(cnt_r) - (FIFO_AW+1)'(1),
    "occupancy did not fall on pop")

endmodule

// ===== rtl/u8s_back.sv =====
// Back end: serialises each result group into single output words.
`include "utf8_sanitizer_top_macros.svh"

module u8s_back
  import u8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  u8s_grp_t   pop_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_stream_end
);

  u8s_grp_t   cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;
  logic       grp_done;

  assign grp_done       = (idx_r == cur_r.cnt_m1);
  assign out_valid      = cur_vld_r;
  assign out_byte       = cur_r.bytes[idx_r];
  assign out_run_last   = grp_done;
  assign out_stream_end = grp_done && cur_r.stream_end;
  assign pop_ready      = !cur_vld_r || (out_ready && grp_done);

  // Step through the current group, load the next one as it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (pop_valid && pop_ready) begin
      cur_vld_r <= 1'b1;
      idx_r     <= 2'd0;
    end else if (cur_vld_r && out_ready) begin
      if (grp_done) begin
        cur_vld_r <= 1'b0;
        idx_r     <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Hold the group payload
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_data;
    end
  end

  `U8S_ASSERT_NOW(a_idx_bound, cur_vld_r, idx_r <= cur_r.cnt_m1,
    "word index past end of group")

endmodule

// ===== rtl/utf8_sanitizer_top.sv =====
// Top level of the UTF-8 sanitizer: front end, group queue and serialiser.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   input   | in_valid in_ready in_byte in_last            | in
//   result  | out_valid out_ready out_byte out_run_last    | out
//           | out_stream_end                               |
//
// A word is accepted in the cycle it arrives while the group queue has room;
// its zero to four results leave the serialiser one per cycle while out_ready
// is high. Sustained rate is then one input word per cycle while each word
// yields at most one result, or one result word per cycle set by the serialiser.
// Reset is synchronous and clears the open sequence, queue and serialiser.
// A stalled result side fills the four-entry queue and then drops in_ready.
module utf8_sanitizer_top
  import u8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_stream_end
);

  logic     push_valid, push_ready;
  logic     pop_valid, pop_ready;
  u8s_grp_t push_data, pop_data;

  u8s_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  u8s_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  u8s_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

endmodule
